### rtl/urs_pkg.sv
// urs_pkg: types and constants shared by the ultrasonic range sequencer
// item structs, config struct, phase enum, register indexes and reset values
// no dependencies
`default_nettype none

package urs_pkg;

  localparam int PERIOD_W   = 20;
  localparam int TRIG_W     = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int RANGE_W    = 16;
  localparam int ELAPSED_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 20'd100000;
  localparam logic [TRIG_W-1:0]    TRIGGER_RST = 8'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd12000;
  localparam logic [RANGE_W-1:0]   MIN_MM_RST  = 16'd20;
  localparam logic [RANGE_W-1:0]   MAX_MM_RST  = 16'd2000;

  // range = echo_us * RANGE_NUM / RANGE_DEN
  localparam logic [63:0] RANGE_NUM = 64'd10;
  localparam logic [63:0] RANGE_DEN = 64'd58;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_FALL
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_US  = 3'd0,
    CFG_TRIGGER_US = 3'd1,
    CFG_TIMEOUT_US = 3'd2,
    CFG_MIN_MM     = 3'd3,
    CFG_MAX_MM     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                 echo_level;
    logic [ELAPSED_W-1:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic               trigger_level;
    logic               range_valid;
    logic [RANGE_W-1:0] range_mm;
    logic               range_timeout;
  } out_item_t;

  typedef struct packed {
    logic trigger_level;
    logic range_valid;
    logic range_timeout;
  } status_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]  period_us;
    logic [TRIG_W-1:0]    trigger_us;
    logic [TIMEOUT_W-1:0] timeout_us;
    logic [RANGE_W-1:0]   min_mm;
    logic [RANGE_W-1:0]   max_mm;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/urs_ctrl.sv
// urs_ctrl: phase state machine and saturating period, phase and echo timers
// updates once per accepted item; depends on urs_pkg
`default_nettype none

module urs_ctrl
  import urs_pkg::*;
#(
  parameter int TIMER_BITS = 17
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire in_item_t              item,
  input  wire cfg_t                  cfg,
  output      status_t               status,
  output      logic [TIMER_BITS-1:0] echo_cnt
);

  localparam int CW = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

  phase_t                  state_r, state_nxt;
  logic [PERIOD_W-1:0]     period_r, period_nxt;
  logic [TIMER_BITS-1:0]   phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]   echo_r, echo_nxt;
  logic                    trigger_r, trigger_nxt;
  logic                    timeout_r, timeout_nxt;
  logic                    done;

  logic [PERIOD_W:0]       period_sum;
  logic [TIMER_BITS:0]     phase_sum;
  logic [TIMER_BITS:0]     echo_sum;
  logic [PERIOD_W-1:0]     period_sat;
  logic [TIMER_BITS-1:0]   phase_sat;
  logic [TIMER_BITS-1:0]   echo_sat;
  logic                    phase_late;
  logic                    echo_late;

  // saturating time advance
  always_comb begin
    period_sum = {1'b0, period_r} + (PERIOD_W+1)'(item.elapsed_us);
    phase_sum  = {1'b0, phase_r} + (TIMER_BITS+1)'(item.elapsed_us);
    echo_sum   = {1'b0, echo_r} + (TIMER_BITS+1)'(item.elapsed_us);
    period_sat = period_sum[PERIOD_W] ? '1 : period_sum[PERIOD_W-1:0];
    phase_sat  = phase_sum[TIMER_BITS] ? '1 : phase_sum[TIMER_BITS-1:0];
    echo_sat   = echo_sum[TIMER_BITS] ? '1 : echo_sum[TIMER_BITS-1:0];
    phase_late = (CW'(phase_sat) > CW'(cfg.timeout_us)) || (&phase_sat);
    echo_late  = (CW'(echo_sat) > CW'(cfg.timeout_us)) || (&echo_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= PH_IDLE;
      period_r  <= '0;
      phase_r   <= '0;
      echo_r    <= '0;
      trigger_r <= 1'b0;
      timeout_r <= 1'b0;
    end else if (accept) begin
      state_r   <= state_nxt;
      period_r  <= period_nxt;
      phase_r   <= phase_nxt;
      echo_r    <= echo_nxt;
      trigger_r <= trigger_nxt;
      timeout_r <= timeout_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    period_nxt  = period_sat;
    phase_nxt   = phase_sat;
    echo_nxt    = echo_sat;
    trigger_nxt = trigger_r;
    timeout_nxt = timeout_r;
    done        = 1'b0;
    unique case (state_r)
      PH_IDLE: begin
        if (period_sat >= cfg.period_us) begin
          period_nxt  = '0;
          phase_nxt   = '0;
          trigger_nxt = 1'b1;
          state_nxt   = PH_TRIG;
        end
      end
      PH_TRIG: begin
        if ((phase_sat >= TIMER_BITS'(cfg.trigger_us)) || (&phase_sat)) begin
          trigger_nxt = 1'b0;
          phase_nxt   = '0;
          state_nxt   = PH_RISE;
        end
      end
      PH_RISE: begin
        if (item.echo_level) begin
          echo_nxt  = '0;
          state_nxt = PH_FALL;
        end else if (phase_late) begin
          timeout_nxt = 1'b1;
          state_nxt   = PH_IDLE;
        end
      end
      PH_FALL: begin
        if (!item.echo_level) begin
          timeout_nxt = 1'b0;
          done        = 1'b1;
          state_nxt   = PH_IDLE;
        end else if (echo_late) begin
          timeout_nxt = 1'b1;
          state_nxt   = PH_IDLE;
        end
      end
      default: state_nxt = PH_IDLE;
    endcase
  end

  assign status.trigger_level = trigger_nxt;
  assign status.range_valid   = done;
  assign status.range_timeout = timeout_nxt;
  assign echo_cnt             = echo_sat;

  a_trigger_in_trig: assert property (@(posedge clk) disable iff (!rst_n)
    trigger_r == (state_r == PH_TRIG))
    else $error("trigger level out of step with phase");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(state_r) && $stable(phase_r) && $stable(echo_r))
    else $error("state moved without an accepted item");

endmodule

`default_nettype wire

### rtl/urs_range.sv
// urs_range: echo time to millimetres by reciprocal multiply, then clamp
// product registered, shift and clamp after it; depends on urs_pkg
`default_nettype none

module urs_range
  import urs_pkg::*;
#(
  parameter int TIMER_BITS = 17
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [TIMER_BITS-1:0] cnt,
  input  wire logic [RANGE_W-1:0]    min_mm,
  input  wire logic [RANGE_W-1:0]    max_mm,
  output      logic [RANGE_W-1:0]    range_mm
);

  // exact floor(cnt*10/58) for every cnt below 2^TIMER_BITS
  localparam int          SHIFT      = TIMER_BITS + 5;
  localparam int          RECIP_W    = TIMER_BITS + 3;
  localparam int          PROD_W     = TIMER_BITS + RECIP_W;
  localparam int          QUO_W      = PROD_W - SHIFT;
  localparam int          CMP_W      = (QUO_W > RANGE_W) ? QUO_W : RANGE_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) * RANGE_NUM + RANGE_DEN - 64'd1) / RANGE_DEN;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

  logic [PROD_W-1:0] prod_r;
  logic [QUO_W-1:0]  quo;
  logic [CMP_W-1:0]  quo_c;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(cnt) * PROD_W'(RECIP);
    end
  end

  always_comb begin
    quo   = prod_r[PROD_W-1:SHIFT];
    quo_c = CMP_W'(quo);
    if (quo_c < CMP_W'(min_mm)) begin
      range_mm = min_mm;
    end else if (quo_c > CMP_W'(max_mm)) begin
      range_mm = max_mm;
    end else begin
      range_mm = quo_c[RANGE_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/ultrasonic_range_sequencer_top.sv
// ultrasonic range sequencer: one result item per input item, registered after
// the control step, the range multiply and the clamp into the output register
// one item per cycle sustained while not stalled; the whole pipeline holds while the output
// register is full and stalled, which is the only source of in_stall
// synchronous active-low reset returns to idle, clears timers, range and flag,
// and loads default config; config port always ready
`default_nettype none

module ultrasonic_range_sequencer_top
  import urs_pkg::*;
#(
  parameter int TIMER_BITS = 17
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire in_item_t              in_item,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      out_item_t             out_item,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                  cfg_r;
  logic                  adv;
  logic                  accept;
  status_t               ctrl_status;
  logic [TIMER_BITS-1:0] ctrl_echo;

  logic                  v1_r, v2_r, out_valid_r;
  status_t               status1_r, status2_r;
  logic [TIMER_BITS-1:0] echo1_r;
  logic [RANGE_W-1:0]    clamped;
  logic [RANGE_W-1:0]    range_sel;
  logic [RANGE_W-1:0]    last_range_r;
  out_item_t             out_item_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_us  <= PERIOD_RST;
      cfg_r.trigger_us <= TRIGGER_RST;
      cfg_r.timeout_us <= TIMEOUT_RST;
      cfg_r.min_mm     <= MIN_MM_RST;
      cfg_r.max_mm     <= MAX_MM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PERIOD_US:  cfg_r.period_us  <= cfg_data[PERIOD_W-1:0];
        CFG_TRIGGER_US: cfg_r.trigger_us <= cfg_data[TRIG_W-1:0];
        CFG_TIMEOUT_US: cfg_r.timeout_us <= cfg_data[TIMEOUT_W-1:0];
        CFG_MIN_MM:     cfg_r.min_mm     <= cfg_data[RANGE_W-1:0];
        CFG_MAX_MM:     cfg_r.max_mm     <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  urs_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .cfg      (cfg_r),
    .status   (ctrl_status),
    .echo_cnt (ctrl_echo)
  );

  urs_range #(
    .TIMER_BITS (TIMER_BITS)
  ) u_range (
    .clk      (clk),
    .en       (adv),
    .cnt      (echo1_r),
    .min_mm   (cfg_r.min_mm),
    .max_mm   (cfg_r.max_mm),
    .range_mm (clamped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status1_r  <= ctrl_status;
      echo1_r    <= ctrl_echo;
      status2_r  <= status1_r;
      out_item_r <= '{trigger_level: status2_r.trigger_level,
                      range_valid:   status2_r.range_valid,
                      range_mm:      range_sel,
                      range_timeout: status2_r.range_timeout};
    end
  end

  assign range_sel = status2_r.range_valid ? clamped : last_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_range_r <= '0;
    end else if (adv && v2_r) begin
      last_range_r <= range_sel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_good_range_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.range_valid |-> !out_item_r.range_timeout)
    else $error("completed range reported with timeout flag");

  a_range_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.range_valid && (cfg_r.min_mm <= cfg_r.max_mm)
    |-> (out_item_r.range_mm >= cfg_r.min_mm) && (out_item_r.range_mm <= cfg_r.max_mm))
    else $error("range outside clamp window");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_last_range_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
    $past(adv) && $past(v2_r) |-> last_range_r == out_item_r.range_mm)
    else $error("held range differs from delivered range");

endmodule

`default_nettype wire

### tb/sv/tb_ultrasonic_range_sequencer_top.sv
// tb_ultrasonic_range_sequencer_top: self-checking bench for the ultrasonic range sequencer
// drives echo samples and register writes with random idling, predicts and compares each item
// depends on urs_pkg and ultrasonic_range_sequencer_top
module tb_ultrasonic_range_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import urs_pkg::*;

  localparam int TIMER_BITS = 17;
  localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;
  localparam int unsigned PERIOD_MAX = (1 << PERIOD_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_PERIOD_US;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the sequencer
  cfg_t sonar_cfg;
  phase_t ph;
  logic [PERIOD_W-1:0] since_start_us;
  logic [TIMER_BITS-1:0] phase_us;
  logic [TIMER_BITS-1:0] echo_us;
  logic [RANGE_W-1:0] range_hold;
  logic timeout_hold;
  logic trig_hold;

  in_item_t echo_samples[$];
  out_item_t sonar_results[$];

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int mismatch_cnt = 0;
  int start_cnt = 0;
  int range_cnt = 0;
  int timeout_cnt = 0;
  int setting_cnt = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;

  ultrasonic_range_sequencer_top #(
    .TIMER_BITS(TIMER_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned sat_add(int unsigned a, int unsigned b, int unsigned cap);
    return (a + b > cap) ? cap : a + b;
  endfunction

  function automatic bit expired(int unsigned count, int unsigned limit);
    return count > limit || count == TIMER_MAX;
  endfunction

  function automatic out_item_t sonar_step(in_item_t s);
    out_item_t r;
    longint unsigned mm;
    logic done;
    done = 1'b0;
    since_start_us = PERIOD_W'(sat_add(32'(since_start_us), 32'(s.elapsed_us), PERIOD_MAX));
    phase_us = TIMER_BITS'(sat_add(32'(phase_us), 32'(s.elapsed_us), TIMER_MAX));
    echo_us = TIMER_BITS'(sat_add(32'(echo_us), 32'(s.elapsed_us), TIMER_MAX));
    case (ph)
      PH_IDLE: begin
        if (since_start_us >= sonar_cfg.period_us) begin
          since_start_us = '0;
          phase_us = '0;
          trig_hold = 1'b1;
          ph = PH_TRIG;
          start_cnt++;
        end
      end
      PH_TRIG: begin
        if (phase_us >= sonar_cfg.trigger_us || phase_us == TIMER_MAX) begin
          trig_hold = 1'b0;
          phase_us = '0;
          ph = PH_RISE;
        end
      end
      PH_RISE: begin
        if (s.echo_level) begin
          echo_us = '0;
          ph = PH_FALL;
        end else if (expired(32'(phase_us), 32'(sonar_cfg.timeout_us))) begin
          timeout_hold = 1'b1;
          ph = PH_IDLE;
          timeout_cnt++;
        end
      end
      default: begin
        if (!s.echo_level) begin
          mm = 64'(echo_us) * RANGE_NUM / RANGE_DEN;
          if (mm < 64'(sonar_cfg.min_mm)) begin
            mm = 64'(sonar_cfg.min_mm);
          end else if (mm > 64'(sonar_cfg.max_mm)) begin
            mm = 64'(sonar_cfg.max_mm);
          end
          range_hold = mm[RANGE_W-1:0];
          timeout_hold = 1'b0;
          done = 1'b1;
          ph = PH_IDLE;
          range_cnt++;
        end else if (expired(32'(echo_us), 32'(sonar_cfg.timeout_us))) begin
          timeout_hold = 1'b1;
          ph = PH_IDLE;
          timeout_cnt++;
        end
      end
    endcase
    r.trigger_level = trig_hold;
    r.range_valid = done;
    r.range_mm = range_hold;
    r.range_timeout = timeout_hold;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    mismatch_cnt++;
    $display("[%0t] %s mismatch at result %0d: got 0x%0h, expected 0x%0h",
             $time, field, checked_cnt, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
        gap_left <= $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (echo_samples.size() > 0) begin
        in_item <= echo_samples.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sonar_results.size() == 0) begin
          report_mismatch("unexpected item", 64'(out_item), 64'd0);
        end else begin
          want = sonar_results.pop_front();
          if (out_item.trigger_level !== want.trigger_level)
            report_mismatch("trigger_level", 64'(out_item.trigger_level),
                            64'(want.trigger_level));
          if (out_item.range_valid !== want.range_valid)
            report_mismatch("range_valid", 64'(out_item.range_valid),
                            64'(want.range_valid));
          if (out_item.range_mm !== want.range_mm)
            report_mismatch("range_mm", 64'(out_item.range_mm), 64'(want.range_mm));
          if (out_item.range_timeout !== want.range_timeout)
            report_mismatch("range_timeout", 64'(out_item.range_timeout),
                            64'(want.range_timeout));
        end
        checked_cnt++;
      end
      if (in_valid && !in_stall) begin
        sonar_results.push_back(sonar_step(in_item));
        accepted_cnt++;
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PERIOD_US:  sonar_cfg.period_us = val[PERIOD_W-1:0];
      CFG_TRIGGER_US: sonar_cfg.trigger_us = val[TRIG_W-1:0];
      CFG_TIMEOUT_US: sonar_cfg.timeout_us = val[TIMEOUT_W-1:0];
      CFG_MIN_MM:     sonar_cfg.min_mm = val[RANGE_W-1:0];
      CFG_MAX_MM:     sonar_cfg.max_mm = val[RANGE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sonar_cfg(input cfg_t c);
    write_reg(CFG_PERIOD_US, CFG_DATA_W'(c.period_us));
    write_reg(CFG_TRIGGER_US, CFG_DATA_W'(c.trigger_us));
    write_reg(CFG_TIMEOUT_US, CFG_DATA_W'(c.timeout_us));
    write_reg(CFG_MIN_MM, CFG_DATA_W'(c.min_mm));
    write_reg(CFG_MAX_MM, CFG_DATA_W'(c.max_mm));
    setting_cnt++;
  endtask

  function automatic cfg_t pick_sonar_cfg();
    cfg_t c;
    c.period_us = PERIOD_W'($urandom_range(0, 3000));
    c.trigger_us = TRIG_W'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: c.timeout_us = TIMEOUT_W'($urandom_range(0, 400));
      1: c.timeout_us = TIMEOUT_W'($urandom_range(400, 4000));
      default: c.timeout_us = TIMEOUT_W'($urandom_range(4000, 65535));
    endcase
    c.min_mm = RANGE_W'($urandom_range(0, 200));
    if ($urandom_range(0, 3) == 0) begin
      c.max_mm = RANGE_W'($urandom_range(0, 32'(c.min_mm)));
    end else begin
      c.max_mm = RANGE_W'($urandom_range(32'(c.min_mm), 3000));
    end
    return c;
  endfunction

  task automatic queue_sample(input logic echo, input logic [ELAPSED_W-1:0] dt);
    in_item_t s;
    s.echo_level = echo;
    s.elapsed_us = dt;
    echo_samples.push_back(s);
    queued_cnt++;
  endtask

  // mostly clean echo pulses with random timing, some raw noise
  task automatic queue_echo_traffic(input int n);
    int stop_at;
    int unsigned span;
    stop_at = queued_cnt + n;
    while (queued_cnt < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_sample(1'($urandom_range(0, 1)), ELAPSED_W'($urandom_range(0, 255)));
      end else begin
        span = ($urandom_range(0, 9) == 0) ? 255 : 63;
        repeat ($urandom_range(1, 30))
          queue_sample(1'b0, ELAPSED_W'($urandom_range(0, span)));
        repeat ($urandom_range(1, 40))
          queue_sample(1'b1, ELAPSED_W'($urandom_range(0, span)));
      end
    end
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || sonar_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    sonar_cfg = '{PERIOD_RST, TRIGGER_RST, TIMEOUT_RST, MIN_MM_RST, MAX_MM_RST};
    ph = PH_IDLE;
    since_start_us = '0;
    phase_us = '0;
    echo_us = '0;
    range_hold = '0;
    timeout_hold = 1'b0;
    trig_hold = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: long period, nothing starts yet
    queue_sample(1'b0, 8'd0);
    queue_sample(1'b1, 8'd255);
    queue_sample(1'b1, 8'd0);
    queue_sample(1'b0, 8'd128);
    queue_sample(1'b1, 8'd1);
    queue_sample(1'b0, 8'd254);
    wait_drained();

    // all registers zero: immediate start, one-step pulse, timeout as soon as any time passes
    c = '0;
    set_sonar_cfg(c);
    queue_sample(1'b0, 8'd0);
    queue_sample(1'b0, 8'd0);
    queue_sample(1'b0, 8'd0);
    queue_sample(1'b0, 8'd1);
    queue_sample(1'b0, 8'd0);
    queue_sample(1'b0, 8'd0);
    queue_sample(1'b1, 8'd0);
    queue_sample(1'b1, 8'd0);
    queue_sample(1'b0, 8'd5);
    wait_drained();

    // crossed clamps
    c.min_mm = 16'd20;
    c.max_mm = 16'd10;
    set_sonar_cfg(c);
    repeat (2) queue_sample(1'b0, 8'd0);
    queue_sample(1'b1, 8'd0);
    queue_sample(1'b0, 8'd100);
    repeat (2) queue_sample(1'b0, 8'd0);
    queue_sample(1'b1, 8'd0);
    queue_sample(1'b0, 8'd255);
    wait_drained();

    for (int k = 0; k < 8; k++) begin
      if (k == 6) begin
        c = '{20'hFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        gap_pct = 10;
        stall_pct = 10;
      end else begin
        c = pick_sonar_cfg();
        gap_pct = (k == 7) ? 0 : (k % 4) * 8;
        stall_pct = (k == 7) ? 0 : ((k + 1) % 4) * 8;
      end
      set_sonar_cfg(c);
      queue_echo_traffic((k == 6) ? 150 : 235);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("checked %0d items over %0d register settings", checked_cnt, setting_cnt);
    $display("%0d trigger pulses, %0d ranges, %0d echo timeouts",
             start_cnt, range_cnt, timeout_cnt);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
